@@ sv/custom_float_add_multiply_top_assert.svh @@
// Assertion macros for the float add/multiply unit.
// Included by custom_float_add_multiply_top.sv; no other dependencies.
`ifndef CUSTOM_FLOAT_ADD_MULTIPLY_TOP_ASSERT_SVH
`define CUSTOM_FLOAT_ADD_MULTIPLY_TOP_ASSERT_SVH

// Property holds every cycle outside reset.
`define CFAM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Antecedent implies consequent in the following cycle.
`define CFAM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/cfam_pkg.sv @@
// Shared types and constants for the float add/multiply unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cfam_pkg;
  localparam int unsigned ExpBits  = 16;
  localparam int unsigned MantBits = 18;
  localparam logic [ExpBits-1:0] ExpBias    = ExpBits'(30000);
  localparam logic [ExpBits-1:0] ExpSpecial = ExpBits'(1) << (ExpBits - 1);

  typedef enum logic {
    FUNC_ADD = 1'b0,
    FUNC_MUL = 1'b1
  } func_e;

  typedef struct packed {
    logic                sign;
    logic [ExpBits-1:0]  exp;
    logic [MantBits-1:0] mant;
  } fnum_t;

  typedef struct packed {
    func_e func;
    fnum_t a;
    fnum_t b;
  } req_t;
endpackage
`default_nettype wire

@@ sv/cfam_core.sv @@
// Combinational add/multiply datapath for the custom float format.
// Depends on cfam_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cfam_core
  import cfam_pkg::*;
(
  input  req_t  req_i,
  output fnum_t res_o
);
  localparam fnum_t NanVal = '{sign: 1'b0, exp: ExpSpecial, mant: MantBits'(1)};

  fnum_t a, b;
  logic  a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
  logic  a_ge;
  logic [ExpBits-1:0]    ediff, e_big;
  logic [MantBits-1:0]   ma, mb, m_small, m_big_op;
  logic [MantBits:0]     msum;
  logic                  s_add;
  fnum_t add_r, mul_r;
  logic [2*MantBits-1:0] prod;
  logic [MantBits:0]     ptop;
  logic [ExpBits-1:0]    emul;

  assign a = req_i.a;
  assign b = req_i.b;
  assign a_zero = (a.exp == '0) && (a.mant == '0);
  assign b_zero = (b.exp == '0) && (b.mant == '0);
  assign a_inf  = (a.exp == ExpSpecial) && (a.mant == '0);
  assign b_inf  = (b.exp == ExpSpecial) && (b.mant == '0);
  assign a_nan  = (a.exp == ExpSpecial) && (a.mant != '0);
  assign b_nan  = (b.exp == ExpSpecial) && (b.mant != '0);

  always_comb begin
    a_ge  = a.exp >= b.exp;
    ediff = a_ge ? (a.exp - b.exp) : (b.exp - a.exp);
    e_big = a_ge ? a.exp : b.exp;
    m_small = a_ge ? b.mant : a.mant;
    m_big_op = a_ge ? a.mant : b.mant;
    if (ediff >= ExpBits'(MantBits)) m_small = '0;
    else m_small = m_small >> ediff;
    ma = a_ge ? m_big_op : m_small;
    mb = a_ge ? m_small : m_big_op;
    if (a.sign == b.sign) begin
      msum  = {1'b0, ma} + {1'b0, mb};
      s_add = a.sign;
    end else if (ma > mb) begin
      msum  = {1'b0, ma - mb};
      s_add = a.sign;
    end else begin
      msum  = {1'b0, mb - ma};
      s_add = b.sign;
    end
    add_r.sign = s_add;
    if (msum[MantBits]) begin
      add_r.mant = msum[MantBits:1];
      add_r.exp  = e_big + ExpBits'(1);
    end else begin
      add_r.mant = msum[MantBits-1:0];
      add_r.exp  = e_big;
    end
    if (a_nan || b_nan) add_r = NanVal;
    else if (a_zero) add_r = b;
    else if (b_zero) add_r = a;
    else if (a_inf) add_r = (b_inf && (a.sign != b.sign)) ? NanVal : a;
    else if (b_inf) add_r = b;
  end

  always_comb begin
    prod = {{MantBits{1'b0}}, a.mant} * {{MantBits{1'b0}}, b.mant};
    ptop = prod[2*MantBits-1:MantBits-1];
    emul = a.exp + b.exp - ExpBias;
    mul_r.sign = a.sign ^ b.sign;
    if (ptop[MantBits]) begin
      mul_r.mant = ptop[MantBits:1];
      mul_r.exp  = emul + ExpBits'(1);
    end else begin
      mul_r.mant = ptop[MantBits-1:0];
      mul_r.exp  = emul;
    end
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) mul_r = NanVal;
    else if (a_inf || b_inf) begin
      mul_r.exp  = ExpSpecial;
      mul_r.mant = '0;
    end
  end

  assign res_o = (req_i.func == FUNC_MUL) ? mul_r : add_r;
endmodule
`default_nettype wire

@@ sv/custom_float_add_multiply_top.sv @@
// Top level of the float add/multiply unit: input register, datapath, result register.
// Depends on cfam_pkg, cfam_core and custom_float_add_multiply_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
// One request per cycle while stall_o is low. A request is registered in req_q
// on entry, computed in one combinational pass through cfam_core, and its
// result registered in res_q on exit. stall_o is high only while both
// registers are full and stall_i is high, so stall_i reaches stall_o
// combinationally.
module custom_float_add_multiply_top
  import cfam_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                stall_o,
  input  wire                 func_i,
  input  wire                 a_sign_i,
  input  wire [ExpBits-1:0]   a_exp_i,
  input  wire [MantBits-1:0]  a_mant_i,
  input  wire                 b_sign_i,
  input  wire [ExpBits-1:0]   b_exp_i,
  input  wire [MantBits-1:0]  b_mant_i,
  output logic                valid_o,
  input  wire                 stall_i,
  output logic                r_sign_o,
  output logic [ExpBits-1:0]  r_exp_o,
  output logic [MantBits-1:0] r_mant_o
);
  `include "custom_float_add_multiply_top_assert.svh"

  logic  in_vld_q, out_vld_q;
  req_t  req_q, req_d;
  fnum_t res_q, res_d;
  logic  out_adv, in_adv;

  assign out_adv = !out_vld_q || !stall_i;
  assign in_adv  = !in_vld_q || out_adv;
  assign stall_o = !in_adv;

  assign req_d = '{func: func_e'(func_i),
                   a: '{sign: a_sign_i, exp: a_exp_i, mant: a_mant_i},
                   b: '{sign: b_sign_i, exp: b_exp_i, mant: b_mant_i}};

  cfam_core u_core (
    .req_i(req_q),
    .res_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_adv) in_vld_q <= valid_i;
      if (out_adv) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && valid_i) req_q <= req_d;
    if (out_adv && in_vld_q) res_q <= res_d;
  end

  assign valid_o  = out_vld_q;
  assign r_sign_o = res_q.sign;
  assign r_exp_o  = res_q.exp;
  assign r_mant_o = res_q.mant;

  `CFAM_ASSERT(a_stall_needs_full, !stall_o || (in_vld_q && out_vld_q))
  `CFAM_ASSERT_NEXT(a_out_holds, valid_o && stall_i, valid_o && $stable(res_q))
  `CFAM_ASSERT_NEXT(a_stage_moves, in_vld_q && !stall_o && !(valid_i), !in_vld_q || valid_o)
endmodule
`default_nettype wire
